// File: hw/rtl/smsq_pkg.sv
// Package for the stepper move sequencer: sizes, command and phase codes,
// and the request and result structs used by smsq_ctrl, the top level and the testbench.
// No dependencies.
package smsq_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned STEP_BITS = 32;
  localparam int unsigned ENTRY_W   = 4;
  localparam int unsigned MC_W      = 5;
  localparam int unsigned SLOT_W    = $clog2(TABLE_DEPTH);
  localparam int unsigned NEXT_W    = $clog2(TABLE_DEPTH + 1);

  localparam logic [MC_W-1:0] MOVE_COUNT_RST = MC_W'(1);
  localparam logic [MC_W-1:0] MOVE_COUNT_MAX = MC_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_POLL  = 2'd2,
    CMD_START = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    PH_RUN  = 4'b0001,
    PH_STOP = 4'b0010,
    PH_ADV  = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  localparam logic [1:0] PH_CODE_RUN  = 2'd0;
  localparam logic [1:0] PH_CODE_STOP = 2'd1;
  localparam logic [1:0] PH_CODE_ADV  = 2'd2;
  localparam logic [1:0] PH_CODE_DONE = 2'd3;

  typedef struct packed {
    cmd_t                 cmd;
    logic [ENTRY_W-1:0]   entry_index;
    logic [STEP_BITS-1:0] entry_steps;
    logic                 entry_dir;
  } item_t;

  typedef struct packed {
    logic               step_pulse;
    logic               dir_level;
    logic               pulse_enable;
    logic               driver_disable;
    logic [1:0]         phase;
    logic [ENTRY_W-1:0] move_index;
    logic               move_finished;
  } result_t;

  // Maps the internal one-hot phase onto the external two-bit code.
  function automatic logic [1:0] phase_code(phase_t ph);
    logic [1:0] code;
    code = PH_CODE_DONE;
    unique case (ph)
      PH_RUN:  code = PH_CODE_RUN;
      PH_STOP: code = PH_CODE_STOP;
      PH_ADV:  code = PH_CODE_ADV;
      PH_DONE: code = PH_CODE_DONE;
      default: code = PH_CODE_DONE;
    endcase
    return code;
  endfunction

endpackage

// File: hw/rtl/smsq_in_if.sv
// Request channel of the stepper move sequencer: valid/ready handshake
// plus the command payload. Depends on smsq_pkg for field widths.
interface smsq_in_if;
  logic                            valid;
  logic                            ready;
  smsq_pkg::cmd_t                  cmd;
  logic [smsq_pkg::ENTRY_W-1:0]    entry_index;
  logic [smsq_pkg::STEP_BITS-1:0]  entry_steps;
  logic                            entry_dir;

  modport source (output valid, cmd, entry_index, entry_steps, entry_dir, input ready);
  modport sink   (input valid, cmd, entry_index, entry_steps, entry_dir, output ready);
endinterface

// File: hw/rtl/smsq_out_if.sv
// Result channel of the stepper move sequencer: valid/ready handshake
// plus the status payload. Depends on smsq_pkg for field widths.
interface smsq_out_if;
  logic                          valid;
  logic                          ready;
  logic                          step_pulse;
  logic                          dir_level;
  logic                          pulse_enable;
  logic                          driver_disable;
  logic [1:0]                    phase;
  logic [smsq_pkg::ENTRY_W-1:0]  move_index;
  logic                          move_finished;

  modport source (output valid, step_pulse, dir_level, pulse_enable, driver_disable,
                  phase, move_index, move_finished, input ready);
  modport sink   (input valid, step_pulse, dir_level, pulse_enable, driver_disable,
                  phase, move_index, move_finished, output ready);
endinterface

// File: hw/rtl/smsq_ctrl.sv
// Sequencer state, move table and per-request update logic.
// Depends on smsq_pkg.
module smsq_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [smsq_pkg::MC_W-1:0]   cfg_wdata,
  input  logic                        go,
  input  smsq_pkg::item_t             item,
  output smsq_pkg::result_t           res
);

  logic [smsq_pkg::MC_W-1:0]      move_count_r;
  smsq_pkg::phase_t               phase_r, phase_nxt;
  logic [smsq_pkg::ENTRY_W-1:0]   cur_r, cur_nxt;
  logic                           started_r, started_nxt;
  logic [smsq_pkg::STEP_BITS-1:0] cnt_r, cnt_nxt;
  logic                           dir_r, dir_nxt;
  logic                           pgen_r, pgen_nxt;
  logic                           drv_off_r, drv_off_nxt;

  logic [smsq_pkg::STEP_BITS-1:0] steps_tab_r [smsq_pkg::TABLE_DEPTH];
  logic                           dir_tab_r   [smsq_pkg::TABLE_DEPTH];

  logic [smsq_pkg::STEP_BITS-1:0] cnt_inc;
  logic [smsq_pkg::STEP_BITS-1:0] cur_steps;
  logic [smsq_pkg::MC_W-1:0]      cnt_sat;
  logic [smsq_pkg::NEXT_W-1:0]    next_idx;
  logic                           pulse, fin;

  assign cnt_inc   = cnt_r + smsq_pkg::STEP_BITS'(1);
  assign cur_steps = steps_tab_r[cur_r[smsq_pkg::SLOT_W-1:0]];
  assign cnt_sat   = (move_count_r > smsq_pkg::MOVE_COUNT_MAX) ? smsq_pkg::MOVE_COUNT_MAX
                                                                : move_count_r;
  // The first advance after a start plays entry zero.
  assign next_idx  = started_r ? (smsq_pkg::NEXT_W'(cur_r) + smsq_pkg::NEXT_W'(1))
                               : '0;

  always_comb begin
    phase_nxt   = phase_r;
    cur_nxt     = cur_r;
    started_nxt = started_r;
    cnt_nxt     = cnt_r;
    dir_nxt     = dir_r;
    pgen_nxt    = pgen_r;
    drv_off_nxt = drv_off_r;
    pulse       = 1'b0;
    fin         = 1'b0;
    if (go) begin
      unique case (item.cmd)
        smsq_pkg::CMD_LOAD: begin
          // Table write is handled in the register block below.
        end
        smsq_pkg::CMD_TICK: begin
          if (phase_r == smsq_pkg::PH_RUN) begin
            cnt_nxt = cnt_inc;
            pulse   = 1'b1;
            if (cnt_inc >= cur_steps) begin
              phase_nxt = smsq_pkg::PH_STOP;
              fin       = 1'b1;
            end
          end
        end
        smsq_pkg::CMD_POLL: begin
          unique case (phase_r)
            smsq_pkg::PH_STOP: begin
              pgen_nxt  = 1'b0;
              phase_nxt = smsq_pkg::PH_ADV;
            end
            smsq_pkg::PH_ADV: begin
              started_nxt = 1'b1;
              if (smsq_pkg::MC_W'(next_idx) < cnt_sat) begin
                cur_nxt   = next_idx[smsq_pkg::ENTRY_W-1:0];
                cnt_nxt   = '0;
                pgen_nxt  = 1'b1;
                dir_nxt   = ~dir_tab_r[next_idx[smsq_pkg::SLOT_W-1:0]];
                phase_nxt = smsq_pkg::PH_RUN;
              end else begin
                phase_nxt = smsq_pkg::PH_DONE;
              end
            end
            smsq_pkg::PH_DONE: begin
              if (started_r) begin
                drv_off_nxt = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        smsq_pkg::CMD_START: begin
          phase_nxt   = smsq_pkg::PH_ADV;
          cur_nxt     = '0;
          started_nxt = 1'b0;
          cnt_nxt     = '0;
          pgen_nxt    = 1'b0;
          drv_off_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_count_r <= smsq_pkg::MOVE_COUNT_RST;
      phase_r      <= smsq_pkg::PH_DONE;
      cur_r        <= '0;
      started_r    <= 1'b0;
      cnt_r        <= '0;
      dir_r        <= 1'b0;
      pgen_r       <= 1'b0;
      drv_off_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        move_count_r <= cfg_wdata;
      end
      phase_r   <= phase_nxt;
      cur_r     <= cur_nxt;
      started_r <= started_nxt;
      cnt_r     <= cnt_nxt;
      dir_r     <= dir_nxt;
      pgen_r    <= pgen_nxt;
      drv_off_r <= drv_off_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && (item.cmd == smsq_pkg::CMD_LOAD)) begin
      steps_tab_r[item.entry_index[smsq_pkg::SLOT_W-1:0]] <= item.entry_steps;
      dir_tab_r[item.entry_index[smsq_pkg::SLOT_W-1:0]]   <= item.entry_dir;
    end
  end

  always_comb begin
    res.step_pulse     = pulse;
    res.dir_level      = dir_nxt;
    res.pulse_enable   = pgen_nxt;
    res.driver_disable = drv_off_nxt;
    res.phase          = smsq_pkg::phase_code(phase_nxt);
    res.move_index     = cur_nxt;
    res.move_finished  = fin;
  end

endmodule

// File: hw/rtl/stepper_move_sequencer_unit.sv
// Top level of the stepper move sequencer: input register, sequencer core
// and result register. Depends on smsq_pkg, smsq_in_if, smsq_out_if, smsq_ctrl.
//
// Usage. Requests arrive on in_chan (valid/ready). Each carries a command:
// load a table entry (slot, step count, direction), a timer tick, a control
// poll, or a start of playback. Every request yields exactly one status result
// on out_chan (valid/ready) showing the step pulse, the direction pin, the pulse
// generator enable, the driver disable, the phase, the entry being played and
// the move-finished flag, all as they stand after the request. The move_count
// register is user-written via cfg_we/cfg_wdata only while idle; not enforced.
//
// Timing. A request taken at a clock edge sits in the input register; it is
// processed when the result register is free or being emptied, and its result
// then enters the result register. One request per cycle is sustained while
// the receiver accepts results; the combinational path between the registers is
// the table read of the current entry plus the 32-bit counter increment and compare.
//
// Reset (synchronous, active low) leaves the block finished with no playback
// started, move_count at one, and both channel registers empty. The table is
// not cleared. When the receiver stalls, the held result stays put, the
// input register holds one more request, and in_chan.ready then drops.
module stepper_move_sequencer_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [smsq_pkg::MC_W-1:0]  cfg_wdata,
  smsq_in_if.sink                    in_chan,
  smsq_out_if.source                 out_chan
);

  logic              in_vld_r;
  smsq_pkg::item_t   in_item_r;
  logic              out_vld_r, out_vld_nxt;
  smsq_pkg::result_t out_res_r;
  smsq_pkg::result_t core_res;
  smsq_pkg::item_t   in_item;
  logic              stage_go;
  logic              in_take;

  // The buffered request moves on when the result register is free or is
  // being emptied in this same cycle.
  assign stage_go      = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !in_vld_r || stage_go;
  assign in_take       = in_chan.valid && in_chan.ready;

  always_comb begin
    in_item.cmd         = in_chan.cmd;
    in_item.entry_index = in_chan.entry_index;
    in_item.entry_steps = in_chan.entry_steps;
    in_item.entry_dir   = in_chan.entry_dir;
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (stage_go) begin
      out_vld_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (stage_go) begin
        in_vld_r <= 1'b0;
      end
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item;
    end
    if (stage_go) begin
      out_res_r <= core_res;
    end
  end

  smsq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .go        (stage_go),
    .item      (in_item_r),
    .res       (core_res)
  );

  assign out_chan.valid          = out_vld_r;
  assign out_chan.step_pulse     = out_res_r.step_pulse;
  assign out_chan.dir_level      = out_res_r.dir_level;
  assign out_chan.pulse_enable   = out_res_r.pulse_enable;
  assign out_chan.driver_disable = out_res_r.driver_disable;
  assign out_chan.phase          = out_res_r.phase;
  assign out_chan.move_index     = out_res_r.move_index;
  assign out_chan.move_finished  = out_res_r.move_finished;

endmodule

// File: tb/stepper_move_sequencer_unit_tb.sv
// Self-checking testbench for stepper_move_sequencer_unit: drives load, tick,
// poll and start requests, predicts every status result and compares it.
// Depends on smsq_pkg, smsq_in_if, smsq_out_if and the unit itself.
module stepper_move_sequencer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import smsq_pkg::*;

  // The bound lies far above any correct run, even with the heaviest
  // stalling, so it only trips on a hang.
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 64;
  localparam int PHASE_REQUESTS = 190;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [MC_W-1:0] cfg_wdata;

  smsq_in_if req_bus();
  smsq_out_if status_bus();

  stepper_move_sequencer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (req_bus),
    .out_chan (status_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Requests waiting to be offered, and status results owed by the unit.
  item_t req_fifo[$];
  result_t status_due[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fails = 0;
  int cycle_count = 0;
  int hold_left = 0;
  logic hold_kick = 1'b0;

  // Shadow state of the sequencer. It is updated once per accepted request,
  // in acceptance order, and the register copy only while the unit is idle.
  logic [MC_W-1:0] sq_move_count = MOVE_COUNT_RST;
  logic [1:0] sq_phase = PH_CODE_DONE;
  logic [ENTRY_W-1:0] sq_entry = '0;
  logic sq_started = 1'b0;
  logic [STEP_BITS-1:0] sq_count = '0;
  logic [STEP_BITS-1:0] sq_steps_tbl[TABLE_DEPTH];
  logic sq_dir_tbl[TABLE_DEPTH];
  logic sq_dir_pin = 1'b0;
  logic sq_pulse_on = 1'b0;
  logic sq_driver_off = 1'b0;

  // What the stimulus generator believes it has loaded. It only plans the
  // number of ticks and makes sure no slot is played before it is loaded.
  logic [STEP_BITS-1:0] plan_steps[TABLE_DEPTH];
  bit plan_written[TABLE_DEPTH];
  int queued = 0;

  // Applies one request to the shadow state and returns the status that the
  // unit must report for it: always the state after the update.
  function automatic result_t sequencer_next_status(item_t rq);
    result_t st;
    logic [MC_W-1:0] limit;
    logic [MC_W-1:0] nxt;
    st = '0;
    case (rq.cmd)
      CMD_LOAD: begin
        sq_steps_tbl[rq.entry_index] = rq.entry_steps;
        sq_dir_tbl[rq.entry_index] = rq.entry_dir;
      end
      CMD_TICK: begin
        // Ticks only count while running; the compare is against the live
        // table entry, so a reload of the playing slot takes effect here.
        if (sq_phase == PH_CODE_RUN) begin
          sq_count = sq_count + 1'b1;
          st.step_pulse = 1'b1;
          if (sq_count >= sq_steps_tbl[sq_entry]) begin
            sq_phase = PH_CODE_STOP;
            st.move_finished = 1'b1;
          end
        end
      end
      CMD_POLL: begin
        case (sq_phase)
          PH_CODE_STOP: begin
            sq_pulse_on = 1'b0;
            sq_phase = PH_CODE_ADV;
          end
          PH_CODE_ADV: begin
            // A count above the table size saturates to the table size.
            limit = (sq_move_count > MOVE_COUNT_MAX) ? MOVE_COUNT_MAX : sq_move_count;
            if (!sq_started) begin
              nxt = '0;
              sq_started = 1'b1;
            end else begin
              nxt = {1'b0, sq_entry} + 1'b1;
            end
            if (nxt < limit) begin
              sq_entry = nxt[ENTRY_W-1:0];
              sq_count = '0;
              sq_pulse_on = 1'b1;
              sq_dir_pin = !sq_dir_tbl[nxt[ENTRY_W-1:0]];
              sq_phase = PH_CODE_RUN;
            end else begin
              sq_phase = PH_CODE_DONE;
            end
          end
          PH_CODE_DONE: begin
            if (sq_started) sq_driver_off = 1'b1;
          end
          default: begin
          end
        endcase
      end
      default: begin
        sq_phase = PH_CODE_ADV;
        sq_entry = '0;
        sq_started = 1'b0;
        sq_count = '0;
        sq_pulse_on = 1'b0;
        sq_driver_off = 1'b0;
      end
    endcase
    st.dir_level = sq_dir_pin;
    st.pulse_enable = sq_pulse_on;
    st.driver_disable = sq_driver_off;
    st.phase = sq_phase;
    st.move_index = sq_entry;
    return st;
  endfunction

  task automatic queue_item(cmd_t cmd, logic [ENTRY_W-1:0] idx, logic [STEP_BITS-1:0] steps,
                            logic dir);
    item_t rq;
    rq.cmd = cmd;
    rq.entry_index = idx;
    rq.entry_steps = steps;
    rq.entry_dir = dir;
    req_fifo.push_back(rq);
    queued++;
    if (cmd == CMD_LOAD) begin
      plan_steps[idx] = steps;
      plan_written[idx] = 1'b1;
    end
  endtask

  // Ticks, polls and starts ignore the load fields, so those carry noise.
  task automatic queue_ctl(cmd_t cmd);
    queue_item(cmd, ENTRY_W'($urandom_range(TABLE_DEPTH - 1)), $urandom, 1'($urandom_range(1)));
  endtask

  // Mostly short moves so that sequences finish; now and then a full-range
  // count, which keeps the upper bits of the field moving.
  function automatic logic [STEP_BITS-1:0] pick_steps();
    if ($urandom_range(15) == 0) return $urandom;
    return STEP_BITS'($urandom_range(5));
  endfunction

  // One well-formed playback of move_count entries with random content,
  // sprinkled with stray requests and the odd restart in the middle.
  task automatic queue_program(int played);
    int s;
    int e;
    int t;
    int ticks;
    for (s = 0; s < played; s++) begin
      if (!plan_written[s] || $urandom_range(2) == 0)
        queue_item(CMD_LOAD, ENTRY_W'(s), pick_steps(), 1'($urandom_range(1)));
    end
    queue_ctl(CMD_START);
    queue_ctl(CMD_POLL);
    for (e = 0; e < played; e++) begin
      if (plan_steps[e] > 8) ticks = $urandom_range(1, 3);
      else if (plan_steps[e] == 0) ticks = 1;
      else ticks = plan_steps[e];
      ticks += $urandom_range(1);
      for (t = 0; t < ticks; t++) begin
        if ($urandom_range(9) == 0) begin
          case ($urandom_range(3))
            0: queue_item(CMD_LOAD, ENTRY_W'($urandom_range(TABLE_DEPTH - 1)), $urandom,
                          1'($urandom_range(1)));
            1: queue_ctl(CMD_POLL);
            2: queue_ctl(CMD_TICK);
            default: queue_ctl(($urandom_range(3) == 0) ? CMD_START : CMD_POLL);
          endcase
        end
        queue_ctl(CMD_TICK);
      end
      queue_ctl(CMD_POLL);
      queue_ctl(CMD_POLL);
    end
    // With every entry played, this poll raises driver disable.
    queue_ctl(CMD_POLL);
  endtask

  // Waits until every request is in and every status has been checked, then
  // keeps watching so that the pipeline can show any stray result.
  task automatic wait_idle();
    while (req_fifo.size() != 0 || req_bus.valid || status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The register is only written between phases, with the unit idle, so the
  // shadow copy can follow it right here.
  task automatic set_move_count(logic [MC_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    sq_move_count = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fails++;
    end
  endtask

  // Request driver. A request accepted at this edge is predicted from the
  // values that the unit actually saw; the next one is then put on the bus.
  // valid gets at most one nonblocking write per edge.
  always @(posedge clk) begin : drive_requests
    item_t seen;
    item_t nxt;
    logic offer;
    if (!rst_n) begin
      req_bus.valid <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        seen = {req_bus.cmd, req_bus.entry_index, req_bus.entry_steps, req_bus.entry_dir};
        status_due.push_back(sequencer_next_status(seen));
      end
      if (!req_bus.valid || req_bus.ready) begin
        offer = (req_fifo.size() != 0) && ($urandom_range(99) >= send_idle_pct);
        if (offer) begin
          nxt = req_fifo.pop_front();
          req_bus.cmd <= nxt.cmd;
          req_bus.entry_index <= nxt.entry_index;
          req_bus.entry_steps <= nxt.entry_steps;
          req_bus.entry_dir <= nxt.entry_dir;
        end
        req_bus.valid <= offer;
      end
    end
  end

  // Status monitor. Every accepted status is matched against the oldest
  // prediction, one field at a time.
  always @(posedge clk) begin : watch_status
    result_t got;
    result_t want;
    if (!rst_n) begin
      status_bus.ready <= 1'b0;
    end else begin
      if (status_bus.valid && status_bus.ready) begin
        got = {status_bus.step_pulse, status_bus.dir_level, status_bus.pulse_enable,
               status_bus.driver_disable, status_bus.phase, status_bus.move_index,
               status_bus.move_finished};
        if (status_due.size() == 0) begin
          $display("%0t ns: status with no request pending, expected none, actual %p",
                   $time, got);
          fails++;
        end else begin
          want = status_due.pop_front();
          compare_field("step_pulse", 32'(want.step_pulse), 32'(got.step_pulse));
          compare_field("dir_level", 32'(want.dir_level), 32'(got.dir_level));
          compare_field("pulse_enable", 32'(want.pulse_enable), 32'(got.pulse_enable));
          compare_field("driver_disable", 32'(want.driver_disable),
                        32'(got.driver_disable));
          compare_field("phase", 32'(want.phase), 32'(got.phase));
          compare_field("move_index", 32'(want.move_index), 32'(got.move_index));
          compare_field("move_finished", 32'(want.move_finished), 32'(got.move_finished));
        end
      end
      status_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, counted here so that the sender keeps offering
  // while the unit's two registers fill and its input ready drops.
  always @(posedge clk) begin : hold_off_counter
    if (hold_kick) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("stepper_move_sequencer_unit test failed");
      $finish;
    end
  end

  initial begin : run_test
    int ph;
    int played;
    logic [MC_W-1:0] mc;
    req_bus.valid = 1'b0;
    req_bus.cmd = CMD_LOAD;
    req_bus.entry_index = '0;
    req_bus.entry_steps = '0;
    req_bus.entry_dir = 1'b0;
    status_bus.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening with move_count at its reset value of one.
    // A poll and a tick before any playback change nothing.
    queue_ctl(CMD_POLL);
    queue_ctl(CMD_TICK);
    // Lowest and highest slot, zero and full-scale step counts.
    queue_item(CMD_LOAD, 4'd0, '0, 1'b1);
    queue_item(CMD_LOAD, 4'd15, '1, 1'b0);
    queue_item(CMD_LOAD, 4'd9, 32'h5555_AAAA, 1'b1);
    // A zero-step move still pulses once and finishes on its first tick.
    queue_ctl(CMD_START);
    queue_ctl(CMD_POLL);
    queue_ctl(CMD_TICK);
    queue_ctl(CMD_TICK);
    queue_ctl(CMD_POLL);
    queue_ctl(CMD_POLL);
    // Poll in finished after a start raises driver disable; ticks are ignored.
    queue_ctl(CMD_POLL);
    queue_ctl(CMD_TICK);
    // Poll while running does nothing; reloading the playing slot with a
    // smaller count makes the next tick finish the move.
    queue_item(CMD_LOAD, 4'd0, 32'd3, 1'b0);
    queue_ctl(CMD_START);
    queue_ctl(CMD_POLL);
    queue_ctl(CMD_POLL);
    queue_ctl(CMD_TICK);
    queue_item(CMD_LOAD, 4'd0, 32'd1, 1'b0);
    queue_ctl(CMD_TICK);
    // Restart from the stopping phase, then a one-step move.
    queue_ctl(CMD_START);
    queue_ctl(CMD_POLL);
    queue_ctl(CMD_TICK);
    wait_idle();

    // Random phases. Each one picks a register setting, including zero
    // entries and values that saturate to the table size, and an idling
    // pattern; every fourth phase runs with no idling at all.
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: mc = MOVE_COUNT_MAX;
        1: mc = '0;
        2: mc = '1;
        3: mc = MC_W'(1);
        4: mc = MC_W'(17);
        default: mc = MC_W'($urandom_range(2, 15));
      endcase
      set_move_count(mc);
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 74;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 74;
        end
        default: begin
          send_idle_pct = 11;
          recv_stall_pct = 11;
        end
      endcase
      played = (mc > MOVE_COUNT_MAX) ? TABLE_DEPTH : mc;
      queued = 0;
      while (queued < PHASE_REQUESTS) queue_program(played);
      // In the first phase the sender never idles, so a long hold-off on the
      // result side backs the whole unit up.
      if (ph == 0) begin
        @(posedge clk);
        hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;
      end
      wait_idle();
    end

    if (fails == 0 && status_due.size() == 0) begin
      $display("stepper_move_sequencer_unit test passed");
    end else begin
      $display("stepper_move_sequencer_unit test failed");
    end
    $finish;
  end

endmodule
